FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the nearest palette color search RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
    label: assert property (@(posedge clk) disable iff (!rst) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: rtl/core/npcs_pkg.sv
// Package for the nearest palette color search: widths, color and tag types,
// and small helper functions. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package npcs_pkg;

    localparam int ENTRIES_DEFAULT = 256;
    localparam int IDX_W           = 8;
    localparam int CH_W            = 8;
    localparam int Q_CH_W          = 5;
    localparam int RGB555_W        = 15;
    localparam int SQ_W            = 16;
    localparam int DIST_W          = 18;
    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

    // One palette entry: red in the low byte, blue in the high byte.
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    localparam int RGB_W = $bits(rgb_t);

    // Travels down the distance pipeline alongside each palette entry.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } scan_tag_t;

    // Expands a 5-bit channel to 8 bits as (v << 3) + 4.
    function automatic logic [CH_W-1:0] expand5(input logic [Q_CH_W-1:0] v);
        return {v, 3'b100};
    endfunction

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/npcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency beyond default widths.
`timescale 1ns / 1ps
`default_nettype none
module npcs_ram #(
    parameter int WIDTH = npcs_pkg::RGB_W,
    parameter int DEPTH = npcs_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/npcs_dist.sv
// Two-stage squared distance unit: per-channel squares, then their sum.
// Depends on npcs_pkg for the widths, the color and tag types and abs_diff.
`timescale 1ns / 1ps
`default_nettype none
module npcs_dist (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire npcs_pkg::scan_tag_t            tag_in,
    input  wire logic                           entry_valid,
    input  wire npcs_pkg::rgb_t                 entry,
    input  wire npcs_pkg::rgb_t                 query,
    output npcs_pkg::scan_tag_t                 tag_out,
    output logic [npcs_pkg::DIST_W-1:0]         sq_dist
);
    import npcs_pkg::*;

    rgb_t            ent;
    logic [SQ_W-1:0] sq_r_reg;
    logic [SQ_W-1:0] sq_g_reg;
    logic [SQ_W-1:0] sq_b_reg;
    scan_tag_t       tag1_reg;
    scan_tag_t       tag2_reg;
    logic [DIST_W-1:0] dist_reg;

    // A never-loaded entry reads as black.
    assign ent = entry_valid ? entry : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQ_W'(abs_diff(query.red,   ent.red))
                  * SQ_W'(abs_diff(query.red,   ent.red));
        sq_g_reg <= SQ_W'(abs_diff(query.green, ent.green))
                  * SQ_W'(abs_diff(query.green, ent.green));
        sq_b_reg <= SQ_W'(abs_diff(query.blue,  ent.blue))
                  * SQ_W'(abs_diff(query.blue,  ent.blue));
        dist_reg <= DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    end

    assign tag_out = tag2_reg;
    assign sq_dist = dist_reg;

endmodule
`default_nettype wire

FILE: rtl/core/nearest_palette_color_search.sv
// Nearest palette color search, top level. A load item gives no result. A
// lookup item scans all PALETTE_ENTRIES entries, one per cycle, through the
// palette RAM read port and the shared distance unit; its result becomes valid
// once the last entry has left the distance unit and no earlier result is
// still held; the block is ready for the next item once it is valid. Reset clears the
// per-entry valid bits at once, so every entry reads as black; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = npcs_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             action,
    input  wire logic [npcs_pkg::IDX_W-1:0]       entry_index,
    input  wire logic [npcs_pkg::CH_W-1:0]        red,
    input  wire logic [npcs_pkg::CH_W-1:0]        green,
    input  wire logic [npcs_pkg::CH_W-1:0]        blue,
    input  wire logic [npcs_pkg::RGB555_W-1:0]    color_rgb555,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [npcs_pkg::IDX_W-1:0]            nearest_index,
    output logic [npcs_pkg::DIST_W-1:0]           distance_squared
);
    import npcs_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
    // The last entry is the transparent color; loads at or beyond it are dropped.
    localparam logic [IDX_W:0] LOAD_LIMIT = (IDX_W + 1)'(PALETTE_ENTRIES - 1);

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       scan_idx_reg, scan_idx_next;
    rgb_t                query_reg, query_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;

    logic [PALETTE_ENTRIES-1:0] ent_valid_reg;
    logic                       rd_valid_reg;
    scan_tag_t                  tag0_reg;
    scan_tag_t                  cmp_tag;
    logic [DIST_W-1:0]          cmp_dist;

    logic    load_we;
    logic    scanning;
    rgb_t    wr_entry;
    rgb_t    rd_entry;

    // A load is taken whenever the block is idle; the write lands at once, so a
    // lookup accepted in the very next cycle already sees it.
    assign in_stall = (state_reg != IDLE);
    assign load_we  = in_valid && !in_stall && (action == ACT_LOAD)
                   && ({1'b0, entry_index} < LOAD_LIMIT);
    assign scanning = (state_reg == SCAN);
    assign wr_entry = '{blue: blue, green: green, red: red};

    npcs_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (load_we),
        .waddr (entry_index[AW-1:0]),
        .wdata (wr_entry),
        .re    (scanning),
        .raddr (scan_idx_reg),
        .rdata (rd_entry)
    );

    // Valid bits stand in for the reset-to-zero contents of the palette. The
    // bit for the current scan address is registered next to the RAM data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            tag0_reg      <= '0;
        end
        else
        begin
            if (load_we)
            begin
                ent_valid_reg[entry_index[AW-1:0]] <= 1'b1;
            end
            rd_valid_reg   <= ent_valid_reg[scan_idx_reg];
            tag0_reg.valid <= scanning;
            tag0_reg.first <= (scan_idx_reg == '0);
            tag0_reg.last  <= (scan_idx_reg == LAST_ADDR);
            tag0_reg.idx   <= IDX_W'(scan_idx_reg);
        end
    end

    npcs_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag_in      (tag0_reg),
        .entry_valid (rd_valid_reg),
        .entry       (rd_entry),
        .query       (query_reg),
        .tag_out     (cmp_tag),
        .sq_dist     (cmp_dist)
    );

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        query_next     = query_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;
        // A waiting result drops once the far side takes it.
        out_valid_next = out_valid_reg && out_stall;

        // Running minimum: only a strictly smaller distance replaces the
        // current best, so the lowest index wins on ties.
        if (cmp_tag.valid && (cmp_tag.first || (cmp_dist < best_dist_reg)))
        begin
            best_idx_next  = cmp_tag.idx;
            best_dist_next = cmp_dist;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (in_valid && (action == ACT_LOOKUP))
                begin
                    query_next.red   = expand5(color_rgb555[4:0]);
                    query_next.green = expand5(color_rgb555[9:5]);
                    query_next.blue  = expand5(color_rgb555[14:10]);
                    scan_idx_next    = '0;
                    state_next       = SCAN;
                end
            end
            SCAN:
            begin
                if (scan_idx_reg == LAST_ADDR)
                begin
                    state_next = DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            DRAIN:
            begin
                if (cmp_tag.valid && cmp_tag.last)
                begin
                    state_next = DONE;
                end
            end
            DONE:
            begin
                // Wait here only while an earlier result is still held.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = best_idx_reg;
                    out_dist_next  = best_dist_reg;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            scan_idx_reg  <= '0;
            query_reg     <= '0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_dist_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            query_reg     <= query_next;
            best_idx_reg  <= best_idx_next;
            best_dist_reg <= best_dist_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_dist_reg  <= out_dist_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign nearest_index    = out_idx_reg;
    assign distance_squared = out_dist_reg;

    // An accepted lookup always starts a scan in the next cycle.
    `ASSERT_NEXT(a_lookup_starts_scan, clk, rst_n, in_valid && !in_stall && action == ACT_LOOKUP, state_reg == SCAN)
    // The transparent entry is never loaded, so it always reads as black.
    `ASSERT_NEVER(a_transparent_unloaded, clk, rst_n, ent_valid_reg[PALETTE_ENTRIES-1])
    // Entries enter the distance pipeline only during a scan or its drain.
    `ASSERT_IMPLIES(a_tag_in_scan, clk, rst_n, tag0_reg.valid, state_reg == SCAN || state_reg == DRAIN)
    // A finished search never reports more than the largest possible distance.
    `ASSERT_IMPLIES(a_best_bounded, clk, rst_n, state_reg == DONE, best_dist_reg <= MAX_DIST)

endmodule
`default_nettype wire

FILE: dv/tb_nearest_palette_color_search.sv
// Self-checking testbench for nearest_palette_color_search: palette loads and
// nearest-color lookups, checked against a behavioral model kept in this file.
// Depends on npcs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_nearest_palette_color_search;

    import npcs_pkg::*;

    // Item codes and fixed palette facts.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;
    localparam int PALETTE_SIZE = ENTRIES_DEFAULT;
    localparam logic [IDX_W-1:0] TRANSPARENT_IDX = IDX_W'(PALETTE_SIZE - 1);

    // One expected lookup answer.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_sq;
    } palette_match_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Every block input starts at a known value.
    logic                  in_valid = 1'b0;
    logic                  action = ACT_LOAD;
    logic [IDX_W-1:0]      entry_index = '0;
    logic [CH_W-1:0]       red = '0;
    logic [CH_W-1:0]       green = '0;
    logic [CH_W-1:0]       blue = '0;
    logic [RGB555_W-1:0]   color_rgb555 = '0;
    logic                  out_stall = 1'b0;

    logic                  in_stall;
    logic                  out_valid;
    logic [IDX_W-1:0]      nearest_index;
    logic [DIST_W-1:0]     distance_squared;

    // Idle rates in percent for the sender and the receiver.
    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 49;
    int unsigned error_count = 0;

    // Shadow copy of the palette and the answers still owed by the block.
    rgb_t           palette_mirror [PALETTE_SIZE];
    palette_match_t pending_matches [$];

    nearest_palette_color_search DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .entry_index      (entry_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .color_rgb555     (color_rgb555),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .nearest_index    (nearest_index),
        .distance_squared (distance_squared)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The slowest correct run is every item a lookup, plus receiver stalls and
    // sender gaps: well under 4 ms. Allow 20 ms.
    initial
    begin
        #20_000_000;
        $display("tb_nearest_palette_color_search failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    // Squared distance from an RGB555 query to every palette entry; the first
    // (lowest) index keeps the lead on equal distances.
    function automatic palette_match_t nearest_entry(input logic [RGB555_W-1:0] color);
        int             qr;
        int             qg;
        int             qb;
        int             dr;
        int             dg;
        int             db;
        int             d;
        int             best;
        palette_match_t found;
        qr = (int'(color[4:0]) << 3) + 4;
        qg = (int'(color[9:5]) << 3) + 4;
        qb = (int'(color[14:10]) << 3) + 4;
        best = 0;
        found = '0;
        for (int i = 0; i < PALETTE_SIZE; i++)
        begin
            dr = qr - int'(palette_mirror[i].red);
            dg = qg - int'(palette_mirror[i].green);
            db = qb - int'(palette_mirror[i].blue);
            d = dr * dr + dg * dg + db * db;
            if (i == 0 || d < best)
            begin
                best = d;
                found.idx = IDX_W'(i);
                found.dist_sq = DIST_W'(best);
            end
        end
        return found;
    endfunction

    // Sends one item and waits for the edge that accepts it. The sender may first
    // idle, with a chance of send_idle_pct percent before the item.
    // Once accepted, the item is applied to the shadow palette or its answer is queued.
    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b,
                             input logic [RGB555_W-1:0] color);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        entry_index  <= idx;
        red          <= r;
        green        <= g;
        blue         <= b;
        color_rgb555 <= color;
        do
            @(posedge clk);
        while (in_stall);
        if (act == ACT_LOAD)
        begin
            // Loads to the transparent entry leave it black.
            if (idx != TRANSPARENT_IDX)
                palette_mirror[idx] = '{blue: b, green: g, red: r};
        end
        else
            pending_matches.push_back(nearest_entry(color));
    endtask

    // Loads carry junk in the query field, lookups junk in the entry fields,
    // so that the block is seen to ignore them.
    task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [CH_W-1:0] r,
                              input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
        send_item(ACT_LOAD, idx, r, g, b, RGB555_W'($urandom));
    endtask

    task automatic lookup_color(input logic [RGB555_W-1:0] color);
        send_item(ACT_LOOKUP, IDX_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                  CH_W'($urandom), color);
    endtask

    // Right after reset the palette is all black, so entry 0 wins every query.
    task automatic test_empty_palette();
        lookup_color(15'h0000);
        lookup_color(15'h7FFF);
        lookup_color(15'h001F);
        lookup_color(15'h03E0);
        lookup_color(15'h7C00);
    endtask

    // A white entry 0 leaves entry 1 the first black one. The transparent
    // entry gets an exact match for the white query; if the load were taken,
    // entry 255 would win at distance zero.
    task automatic test_load_rules();
        load_entry(8'd0, 8'hFF, 8'hFF, 8'hFF);
        lookup_color(15'h7FFF);
        lookup_color(15'h0000);
        load_entry(TRANSPARENT_IDX, 8'd252, 8'd252, 8'd252);
        lookup_color(15'h7FFF);
    endtask

    // Equal colors at several indexes must resolve to the lowest one.
    task automatic test_tie_breaking();
        load_entry(8'd200, 8'd4, 8'd4, 8'd4);
        load_entry(8'd3, 8'd4, 8'd4, 8'd4);
        lookup_color(15'h0000);
        load_entry(8'd254, 8'h55, 8'hAA, 8'h55);
        load_entry(8'd1, 8'h00, 8'hFF, 8'h00);
        lookup_color({5'(8'h55 >> 3), 5'(8'hAA >> 3), 5'(8'h55 >> 3)});
        lookup_color(15'h03E0);
        load_entry(8'd3, 8'hAA, 8'h55, 8'hAA);
        lookup_color(15'h0000);
    endtask

    // Random mix of loads and lookups. Loads often use exact expansions of a
    // 5-bit channel or one of a few shared colors, so that lookups see zero
    // distances and ties. Half the lookups aim near a color already in the
    // palette, the rest are anywhere in RGB555.
    task automatic run_random_traffic(input int count);
        rgb_t                shared_colors [4];
        rgb_t                pick;
        logic [IDX_W-1:0]    idx;
        logic [RGB555_W-1:0] color;
        int unsigned         mode;
        foreach (shared_colors[k])
            shared_colors[k] = RGB_W'($urandom);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 55)
            begin
                idx = ($urandom_range(99) < 3) ? TRANSPARENT_IDX
                                               : IDX_W'($urandom_range(0, PALETTE_SIZE - 2));
                mode = $urandom_range(2);
                if (mode == 0)
                    pick = RGB_W'($urandom);
                else if (mode == 1)
                    pick = '{blue: {5'($urandom), 3'b100}, green: {5'($urandom), 3'b100},
                             red: {5'($urandom), 3'b100}};
                else
                    pick = shared_colors[$urandom_range(3)];
                load_entry(idx, pick.red, pick.green, pick.blue);
            end
            else
            begin
                if ($urandom_range(1) == 0)
                    color = RGB555_W'($urandom);
                else
                begin
                    pick = palette_mirror[$urandom_range(0, PALETTE_SIZE - 1)];
                    color = {pick.blue[7:3], pick.green[7:3], pick.red[7:3]};
                    if ($urandom_range(1) == 0)
                        color[$urandom_range(RGB555_W - 1)] ^= 1'b1;
                end
                lookup_color(color);
            end
        end
    endtask

    task automatic test_random_slow_receiver();
        send_idle_pct = 8;
        recv_idle_pct = 49;
        run_random_traffic(380);
    endtask

    task automatic test_random_slow_sender();
        send_idle_pct = 49;
        recv_idle_pct = 8;
        run_random_traffic(380);
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(380);
    endtask

    // Result side: a result is taken at an edge where out_valid is high and
    // out_stall was low, and is compared with the oldest queued answer. The
    // stall for the next cycle is drawn at every edge out of reset.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_matches.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with no lookup pending, index %0d distance %0d",
                             $time, nearest_index, distance_squared);
                end
                else
                begin
                    if (nearest_index !== pending_matches[0].idx)
                        report_mismatch("nearest_index", nearest_index,
                                        pending_matches[0].idx);
                    if (distance_squared !== pending_matches[0].dist_sq)
                        report_mismatch("distance_squared", distance_squared,
                                        pending_matches[0].dist_sq);
                    void'(pending_matches.pop_front());
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        foreach (palette_mirror[k])
            palette_mirror[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_palette();
        test_load_rules();
        test_tie_breaking();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_full_rate();
        in_valid <= 1'b0;

        // Wait for every owed answer, then watch a full scan longer for
        // anything extra.
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (PALETTE_SIZE + 40) @(posedge clk);

        if (error_count == 0)
            $display("tb_nearest_palette_color_search passed");
        else
            $display("tb_nearest_palette_color_search failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/npcs_pkg.sv
rtl/core/npcs_ram.sv
rtl/core/npcs_dist.sv
rtl/core/nearest_palette_color_search.sv
dv/tb_nearest_palette_color_search.sv
